// File: hdl/vn2d_pkg.sv
package vn2d_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W = 32;
   localparam int NOISE_W = 24;
   localparam int HASH_W = 64;
   localparam int HALF_W = 32;

   localparam logic [HASH_W-1:0] HASH_KX = 64'h9E3779B97F4A7C15;
   localparam logic [HASH_W-1:0] HASH_KZ = 64'hC2B2AE3D27D4EB4F;
   localparam logic [HASH_W-1:0] HASH_KS = 64'h165667B19E3779F9;
   localparam logic [HASH_W-1:0] HASH_KM = 64'hBF58476D1CE4E5B9;
   localparam int FOLD_A = 31;
   localparam int FOLD_B = 29;

   localparam int NUM_SRC = 5;
   localparam int SRC_X0 = 0;
   localparam int SRC_X1 = 1;
   localparam int SRC_Z0 = 2;
   localparam int SRC_Z1 = 3;
   localparam int SRC_SEED = 4;
   localparam int NUM_CORNERS = 4;

   localparam int ST_CELL = 1;
   localparam int ST_MUL1 = 2;
   localparam int ST_MIX = 3;
   localparam int ST_MUL2 = 4;
   localparam int ST_FOLD = 5;
   localparam int ST_LERP_X = 6;
   localparam int ST_LERP_Z = 7;
   localparam int NUM_STAGES = 7;

   typedef logic [NUM_STAGES:1] stage_en_type;
   typedef logic [FRAC_BITS-1:0] frac_type;
   typedef logic [NOISE_W-1:0] noise_type;
   typedef logic [COORD_W-1:0] word_type;

   typedef struct packed {
      word_type x0;
      word_type x1;
      word_type z0;
      word_type z1;
      word_type seed;
   } cell_set_type;

   typedef struct packed {
      noise_type v00;
      noise_type v10;
      noise_type v01;
      noise_type v11;
   } corner_set_type;

endpackage

// File: hdl/vn2d_hash.sv
module vn2d_hash (
   input  logic                      clock,
   input  vn2d_pkg::stage_en_type    en,
   input  vn2d_pkg::cell_set_type    cells,
   output vn2d_pkg::corner_set_type  corners
);

   localparam int CX [vn2d_pkg::NUM_CORNERS] =
      '{vn2d_pkg::SRC_X0, vn2d_pkg::SRC_X1, vn2d_pkg::SRC_X0, vn2d_pkg::SRC_X1};
   localparam int CZ [vn2d_pkg::NUM_CORNERS] =
      '{vn2d_pkg::SRC_Z0, vn2d_pkg::SRC_Z0, vn2d_pkg::SRC_Z1, vn2d_pkg::SRC_Z1};

   vn2d_pkg::word_type            src [vn2d_pkg::NUM_SRC];
   logic [vn2d_pkg::HASH_W-1:0]   kc  [vn2d_pkg::NUM_SRC];

   logic [vn2d_pkg::HASH_W-1:0]   lo_in  [vn2d_pkg::NUM_SRC];
   logic [vn2d_pkg::HASH_W-1:0]   lo_ff  [vn2d_pkg::NUM_SRC];
   vn2d_pkg::word_type            hi_in  [vn2d_pkg::NUM_SRC];
   vn2d_pkg::word_type            hi_ff  [vn2d_pkg::NUM_SRC];

   logic [vn2d_pkg::HASH_W-1:0]   g_in   [vn2d_pkg::NUM_CORNERS];
   logic [vn2d_pkg::HASH_W-1:0]   g_ff   [vn2d_pkg::NUM_CORNERS];

   logic [vn2d_pkg::HASH_W-1:0]   ll_in  [vn2d_pkg::NUM_CORNERS];
   logic [vn2d_pkg::HASH_W-1:0]   ll_ff  [vn2d_pkg::NUM_CORNERS];
   vn2d_pkg::word_type            lh_in  [vn2d_pkg::NUM_CORNERS];
   vn2d_pkg::word_type            lh_ff  [vn2d_pkg::NUM_CORNERS];
   vn2d_pkg::word_type            hl_in  [vn2d_pkg::NUM_CORNERS];
   vn2d_pkg::word_type            hl_ff  [vn2d_pkg::NUM_CORNERS];

   vn2d_pkg::noise_type           v_in   [vn2d_pkg::NUM_CORNERS];
   vn2d_pkg::noise_type           v_ff   [vn2d_pkg::NUM_CORNERS];

   always_comb begin
      src[vn2d_pkg::SRC_X0]   = cells.x0;
      src[vn2d_pkg::SRC_X1]   = cells.x1;
      src[vn2d_pkg::SRC_Z0]   = cells.z0;
      src[vn2d_pkg::SRC_Z1]   = cells.z1;
      src[vn2d_pkg::SRC_SEED] = cells.seed;
      kc[vn2d_pkg::SRC_X0]    = vn2d_pkg::HASH_KX;
      kc[vn2d_pkg::SRC_X1]    = vn2d_pkg::HASH_KX;
      kc[vn2d_pkg::SRC_Z0]    = vn2d_pkg::HASH_KZ;
      kc[vn2d_pkg::SRC_Z1]    = vn2d_pkg::HASH_KZ;
      kc[vn2d_pkg::SRC_SEED]  = vn2d_pkg::HASH_KS;
   end

   // A 32-bit value times a 64-bit constant, kept modulo 2^64, is split into a full
   // low product and the low half of the high product.
   always_comb begin
      for (int i = 0; i < vn2d_pkg::NUM_SRC; i++) begin
         lo_in[i] = vn2d_pkg::HASH_W'(src[i]) *
                    vn2d_pkg::HASH_W'(kc[i][vn2d_pkg::HALF_W-1:0]);
         hi_in[i] = vn2d_pkg::HALF_W'(src[i] *
                    kc[i][vn2d_pkg::HASH_W-1:vn2d_pkg::HALF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_MUL1]) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_comb begin
      logic [vn2d_pkg::HASH_W-1:0] prod [vn2d_pkg::NUM_SRC];
      logic [vn2d_pkg::HASH_W-1:0] h;
      for (int i = 0; i < vn2d_pkg::NUM_SRC; i++) begin
         prod[i] = lo_ff[i] + {hi_ff[i], vn2d_pkg::HALF_W'(0)};
      end
      for (int c = 0; c < vn2d_pkg::NUM_CORNERS; c++) begin
         h = prod[CX[c]] ^ prod[CZ[c]] ^ prod[vn2d_pkg::SRC_SEED];
         g_in[c] = h ^ (h >> vn2d_pkg::FOLD_A);
      end
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_MIX]) begin
         g_ff <= g_in;
      end
   end

   always_comb begin
      for (int c = 0; c < vn2d_pkg::NUM_CORNERS; c++) begin
         ll_in[c] = vn2d_pkg::HASH_W'(g_ff[c][vn2d_pkg::HALF_W-1:0]) *
                    vn2d_pkg::HASH_W'(vn2d_pkg::HASH_KM[vn2d_pkg::HALF_W-1:0]);
         lh_in[c] = vn2d_pkg::HALF_W'(g_ff[c][vn2d_pkg::HASH_W-1:vn2d_pkg::HALF_W] *
                    vn2d_pkg::HASH_KM[vn2d_pkg::HALF_W-1:0]);
         hl_in[c] = vn2d_pkg::HALF_W'(g_ff[c][vn2d_pkg::HALF_W-1:0] *
                    vn2d_pkg::HASH_KM[vn2d_pkg::HASH_W-1:vn2d_pkg::HALF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_MUL2]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
      end
   end

   always_comb begin
      logic [vn2d_pkg::HASH_W-1:0] m;
      logic [vn2d_pkg::HASH_W-1:0] f;
      for (int c = 0; c < vn2d_pkg::NUM_CORNERS; c++) begin
         m = ll_ff[c] + {lh_ff[c] + hl_ff[c], vn2d_pkg::HALF_W'(0)};
         f = m ^ (m >> vn2d_pkg::FOLD_B);
         v_in[c] = f[vn2d_pkg::HASH_W-1 -: vn2d_pkg::NOISE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_FOLD]) begin
         v_ff <= v_in;
      end
   end

   assign corners.v00 = v_ff[0];
   assign corners.v10 = v_ff[1];
   assign corners.v01 = v_ff[2];
   assign corners.v11 = v_ff[3];

endmodule

// File: hdl/vn2d_ease.sv
module vn2d_ease (
   input  logic                    clock,
   input  vn2d_pkg::stage_en_type  en,
   input  vn2d_pkg::frac_type      fx,
   input  vn2d_pkg::frac_type      fz,
   output vn2d_pkg::frac_type      ux,
   output vn2d_pkg::frac_type      uz
);

   localparam int SQ_W = 2 * vn2d_pkg::FRAC_BITS;
   localparam int K_W = vn2d_pkg::FRAC_BITS + 2;
   localparam int P_W = 2 * vn2d_pkg::FRAC_BITS + 2;
   localparam logic [K_W-1:0] K_BASE = K_W'(3) << vn2d_pkg::FRAC_BITS;

   vn2d_pkg::frac_type  t      [2];
   logic [SQ_W-1:0]     sq_in  [2];
   logic [SQ_W-1:0]     sq_ff  [2];
   logic [K_W-1:0]      k_in   [2];
   logic [K_W-1:0]      k_ff   [2];
   vn2d_pkg::frac_type  u3_in  [2];
   vn2d_pkg::frac_type  u3_ff  [2];
   vn2d_pkg::frac_type  u4_ff  [2];
   vn2d_pkg::frac_type  u5_ff  [2];
   vn2d_pkg::frac_type  uz6_ff;

   always_comb begin
      t[0] = fx;
      t[1] = fz;
      for (int i = 0; i < 2; i++) begin
         sq_in[i] = SQ_W'(t[i]) * SQ_W'(t[i]);
         k_in[i]  = K_BASE - {1'b0, t[i], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_MUL1]) begin
         sq_ff <= sq_in;
         k_ff  <= k_in;
      end
   end

   // The eased value is always below one, so the upper product bits are zero.
   always_comb begin
      logic [P_W-1:0] p;
      for (int i = 0; i < 2; i++) begin
         p = P_W'(sq_ff[i][SQ_W-1:vn2d_pkg::FRAC_BITS]) * P_W'(k_ff[i]);
         u3_in[i] = p[SQ_W-1:vn2d_pkg::FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_MIX]) begin
         u3_ff <= u3_in;
      end
      if (en[vn2d_pkg::ST_MUL2]) begin
         u4_ff <= u3_ff;
      end
      if (en[vn2d_pkg::ST_FOLD]) begin
         u5_ff <= u4_ff;
      end
      if (en[vn2d_pkg::ST_LERP_X]) begin
         uz6_ff <= u5_ff[1];
      end
   end

   assign ux = u5_ff[0];
   assign uz = uz6_ff;

endmodule

// File: hdl/vn2d_lerp.sv
module vn2d_lerp (
   input  logic                 clock,
   input  logic                 load,
   input  vn2d_pkg::noise_type  a,
   input  vn2d_pkg::noise_type  b,
   input  vn2d_pkg::frac_type   u,
   output vn2d_pkg::noise_type  y
);

   localparam int D_W = vn2d_pkg::NOISE_W + 1;
   localparam int P_W = D_W + vn2d_pkg::FRAC_BITS + 1;

   logic signed [D_W-1:0]  diff;
   logic signed [P_W-1:0]  prod;
   logic signed [P_W-1:0]  step;
   vn2d_pkg::noise_type    y_in;
   vn2d_pkg::noise_type    y_ff;

   // The blend is written as a plus a floored fraction of the difference, which
   // equals the weighted sum of both ends and always stays between them.
   always_comb begin
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = P_W'(diff) * P_W'($signed({1'b0, u}));
      step = prod >>> vn2d_pkg::FRAC_BITS;
      y_in = a + step[vn2d_pkg::NOISE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// File: hdl/value_noise_2d_sampler_unit.sv
// Two-dimensional value noise sampler: each request carries a signed Q16.16 coordinate
// pair and a 32-bit seed, and each returns one unsigned Q0.24 noise value in [0, 1).
// The unit is a seven-stage pipeline that accepts one request every clock cycle while the
// response side is ready, and its result is the output of the last blend register; the
// depth is set by the input stage that splits cell and fraction, the two 64-bit hash
// multiplications, each split into 32-bit partial products over two stages, and the two
// blend stages. Results leave in request order, and a stall on the response side only
// holds back the stages that are full, so bubbles still drain. The unit has no state
// beyond the pipeline and reset only clears the valid flags.
module value_noise_2d_sampler_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_x_coord,
   input  logic signed [31:0]          req_z_coord,
   input  logic signed [31:0]          req_noise_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [23:0]                 rsp_noise_value
);

   vn2d_pkg::stage_en_type    valid_ff;
   vn2d_pkg::stage_en_type    valid_in;
   vn2d_pkg::stage_en_type    valid_prev;
   vn2d_pkg::stage_en_type    stage_rdy;
   vn2d_pkg::stage_en_type    en;

   vn2d_pkg::cell_set_type    cells_in;
   vn2d_pkg::cell_set_type    cells_ff;
   vn2d_pkg::frac_type        fx_ff;
   vn2d_pkg::frac_type        fz_ff;

   vn2d_pkg::corner_set_type  corners;
   vn2d_pkg::frac_type        ux;
   vn2d_pkg::frac_type        uz;
   vn2d_pkg::noise_type       near_row;
   vn2d_pkg::noise_type       far_row;

   always_comb begin
      stage_rdy[vn2d_pkg::NUM_STAGES] = !valid_ff[vn2d_pkg::NUM_STAGES] || rsp_ready;
      for (int s = vn2d_pkg::NUM_STAGES - 1; s >= 1; s--) begin
         stage_rdy[s] = !valid_ff[s] || stage_rdy[s + 1];
      end
      valid_prev[1] = req_valid;
      for (int s = 2; s <= vn2d_pkg::NUM_STAGES; s++) begin
         valid_prev[s] = valid_ff[s - 1];
      end
      for (int s = 1; s <= vn2d_pkg::NUM_STAGES; s++) begin
         en[s]       = stage_rdy[s] && valid_prev[s];
         valid_in[s] = stage_rdy[s] ? valid_prev[s] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The cell is the floor of the coordinate; the fraction is its low bits.
   always_comb begin
      cells_in.x0   = vn2d_pkg::COORD_W'(req_x_coord >>> vn2d_pkg::FRAC_BITS);
      cells_in.z0   = vn2d_pkg::COORD_W'(req_z_coord >>> vn2d_pkg::FRAC_BITS);
      cells_in.x1   = cells_in.x0 + vn2d_pkg::COORD_W'(1);
      cells_in.z1   = cells_in.z0 + vn2d_pkg::COORD_W'(1);
      cells_in.seed = $unsigned(req_noise_seed);
   end

   always_ff @(posedge clock) begin
      if (en[vn2d_pkg::ST_CELL]) begin
         cells_ff <= cells_in;
         fx_ff    <= req_x_coord[vn2d_pkg::FRAC_BITS-1:0];
         fz_ff    <= req_z_coord[vn2d_pkg::FRAC_BITS-1:0];
      end
   end

   vn2d_hash u_hash (
      .clock   (clock),
      .en      (en),
      .cells   (cells_ff),
      .corners (corners)
   );

   vn2d_ease u_ease (
      .clock (clock),
      .en    (en),
      .fx    (fx_ff),
      .fz    (fz_ff),
      .ux    (ux),
      .uz    (uz)
   );

   vn2d_lerp u_lerp_near (
      .clock (clock),
      .load  (en[vn2d_pkg::ST_LERP_X]),
      .a     (corners.v00),
      .b     (corners.v10),
      .u     (ux),
      .y     (near_row)
   );

   vn2d_lerp u_lerp_far (
      .clock (clock),
      .load  (en[vn2d_pkg::ST_LERP_X]),
      .a     (corners.v01),
      .b     (corners.v11),
      .u     (ux),
      .y     (far_row)
   );

   vn2d_lerp u_lerp_z (
      .clock (clock),
      .load  (en[vn2d_pkg::ST_LERP_Z]),
      .a     (near_row),
      .b     (far_row),
      .u     (uz),
      .y     (rsp_noise_value)
   );

   assign req_ready = stage_rdy[1];
   assign rsp_valid = valid_ff[vn2d_pkg::NUM_STAGES];

endmodule

// File: hdl/vn2d_checker.sv
module vn2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_noise_value
);

   // A response that is held back keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_value))
      else $error("Stalled response changed or was dropped.");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid straight after reset.");

   // With the response side ready the pipeline never pushes back.
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("Request refused although the response side is ready.");

   // An unstalled request comes out after the full pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("Response missing after the pipeline depth.");

endmodule

bind value_noise_2d_sampler_unit vn2d_checker u_checker (.*);

// File: tb/value_noise_2d_sampler_unit_tb.sv
module value_noise_2d_sampler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM = 1100;
   localparam int IDLE_PERCENT = 31;
   localparam int HOLD_AFTER = 200;
   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;

   class noise_scoreboard;
      vn2d_pkg::noise_type expected_noise[$];
      int requests_seen;
      int responses_checked;
      int mismatches;

      function bit [63:0] ease_frac(bit [63:0] t);
         bit [63:0] one;
         bit [63:0] t2;
         one = 64'd1 << vn2d_pkg::FRAC_BITS;
         t2 = (t * t) >> vn2d_pkg::FRAC_BITS;
         return (t2 * (3 * one - 2 * t)) >> vn2d_pkg::FRAC_BITS;
      endfunction

      function bit [63:0] lattice_hash(vn2d_pkg::word_type cx, vn2d_pkg::word_type cz,
                                       vn2d_pkg::word_type seed);
         bit [63:0] h;
         h = {32'd0, cx} * vn2d_pkg::HASH_KX;
         h ^= {32'd0, cz} * vn2d_pkg::HASH_KZ;
         h ^= {32'd0, seed} * vn2d_pkg::HASH_KS;
         h = (h ^ (h >> vn2d_pkg::FOLD_A)) * vn2d_pkg::HASH_KM;
         h ^= h >> vn2d_pkg::FOLD_B;
         return h >> 40;
      endfunction

      function bit [63:0] lerp(bit [63:0] a, bit [63:0] b, bit [63:0] u);
         bit [63:0] one;
         one = 64'd1 << vn2d_pkg::FRAC_BITS;
         return (a * (one - u) + b * u) >> vn2d_pkg::FRAC_BITS;
      endfunction

      function vn2d_pkg::noise_type sample_noise(vn2d_pkg::word_type xv,
                                                 vn2d_pkg::word_type zv,
                                                 vn2d_pkg::word_type seed);
         vn2d_pkg::word_type x0;
         vn2d_pkg::word_type z0;
         bit [63:0] ux;
         bit [63:0] uz;
         bit [63:0] a;
         bit [63:0] b;
         x0 = $signed(xv) >>> vn2d_pkg::FRAC_BITS;
         z0 = $signed(zv) >>> vn2d_pkg::FRAC_BITS;
         ux = ease_frac({48'd0, xv[vn2d_pkg::FRAC_BITS-1:0]});
         uz = ease_frac({48'd0, zv[vn2d_pkg::FRAC_BITS-1:0]});
         a = lerp(lattice_hash(x0, z0, seed), lattice_hash(x0 + 1, z0, seed), ux);
         b = lerp(lattice_hash(x0, z0 + 1, seed), lattice_hash(x0 + 1, z0 + 1, seed), ux);
         return vn2d_pkg::noise_type'(lerp(a, b, uz));
      endfunction

      function void note_request(vn2d_pkg::word_type xv, vn2d_pkg::word_type zv,
                                 vn2d_pkg::word_type seed);
         expected_noise.insert(expected_noise.size(), sample_noise(xv, zv, seed));
         requests_seen++;
      endfunction

      task report_mismatch(string what, vn2d_pkg::noise_type got,
                           vn2d_pkg::noise_type want);
         $display("MISMATCH %s: got %06h, expected %06h", what, got, want);
         mismatches++;
      endtask

      task check_response(vn2d_pkg::noise_type got);
         vn2d_pkg::noise_type want;
         responses_checked++;
         if (expected_noise.size() == 0) begin
            report_mismatch("response with no request pending", got, '0);
         end else begin
            want = expected_noise.pop_front();
            if (got !== want) begin
               report_mismatch("noise_value", got, want);
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_z_coord = '0;
   logic signed [31:0] req_noise_seed = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_noise_value;

   bit steady_flow = 1'b0;
   bit held_off = 1'b0;
   noise_scoreboard board = new();

   value_noise_2d_sampler_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_x_coord(req_x_coord),
      .req_z_coord(req_z_coord),
      .req_noise_seed(req_noise_seed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_noise_value(rsp_noise_value)
   );

   always #10 clock = ~clock;

   task automatic send_request(vn2d_pkg::word_type xv, vn2d_pkg::word_type zv,
                               vn2d_pkg::word_type seed);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_coord <= xv;
      req_z_coord <= zv;
      req_noise_seed <= seed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_x_coord, req_z_coord, req_noise_seed);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_noise_value);
         end
      end
   end

   // The receiver holds off once for a long stretch so that the pipeline fills and
   // pushes back on the request side.
   initial begin
      forever begin
         @(posedge clock);
         if (!held_off && board.requests_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      vn2d_pkg::word_type xv;
      vn2d_pkg::word_type zv;
      vn2d_pkg::word_type seed;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_request(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
      send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
      send_request(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0000);
      send_request(32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_8000, 32'h0000_8000, 32'hDEAD_BEEF);
      send_request(32'h7FFF_0000, 32'h8000_FFFF, 32'h0000_0001);
      send_request(32'h0001_0000, 32'hFFFE_FFFF, 32'hA5A5_A5A5);
      send_request(32'h0000_0001, 32'h0000_8000, 32'h5A5A_5A5A);
      send_request(32'h0000_7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h8000_0001, 32'h0000_0000, 32'h8000_0000);
      send_request(32'h0012_3456, 32'hFFED_CBA9, 32'h0000_0000);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         steady_flow = (i >= 400 && i < 650);
         xv = $urandom;
         zv = $urandom;
         seed = $urandom;
         case ($urandom_range(9))
            0, 1, 2, 3: begin
            end
            4, 5: begin
               xv = $urandom_range(32'h3FFFF) - 32'h20000;
               zv = $urandom_range(32'h3FFFF) - 32'h20000;
            end
            6: begin
               xv[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               zv[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            7: begin
               xv[31:16] = 16'hFFFF;
               zv[31:16] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            8: begin
               xv = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               zv = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            default: begin
               seed = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
         endcase
         send_request(xv, zv, seed);
      end
      req_valid <= 1'b0;
      steady_flow = 1'b0;

      while (board.expected_noise.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d samples: lattice edges, cell wrap, negative and extreme coordinates,",
               board.requests_seen);
      $display("random seeds, one long response stall; %0d results checked, %0d mismatches.",
               board.responses_checked, board.mismatches);
      if (board.mismatches == 0 && board.expected_noise.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/vn2d_pkg.sv
hdl/vn2d_hash.sv
hdl/vn2d_ease.sv
hdl/vn2d_lerp.sv
hdl/value_noise_2d_sampler_unit.sv
hdl/vn2d_checker.sv
tb/value_noise_2d_sampler_unit_tb.sv
